FILE: rtl/core/gcre_pkg.sv
// ----------------------------------------------------------------------------
// GCR 6-and-2 encoder package
// Operation codes, the job record passed from the front to the back end and
// the 64-entry 6-and-2 code table.
// ----------------------------------------------------------------------------
package gcre_pkg;

   typedef enum logic [1:0] {
      OP_DATA     = 2'd0,
      OP_START    = 2'd1,
      OP_STOP     = 2'd2,
      OP_STOP_SUM = 2'd3
   } gcre_op_type;

   // Most disk bytes one item can cause: a flushed partial group and a sum group.
   localparam int MAX_BYTES          = 7;
   localparam int JOB_DEPTH_DEFAULT  = 4;

   // One job is either a single raw byte or a list of table indexes.
   typedef struct packed {
      logic                       raw;
      logic                       err;
      logic [7:0]                 raw_byte;
      logic [2:0]                 count;
      logic [MAX_BYTES-1:0][5:0]  idx;
   } gcre_job_type;

   localparam logic [7:0] GCR_TABLE [64] = '{
      8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
      8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
      8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
      8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
      8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
      8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
      8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
      8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
   };

endpackage

FILE: rtl/core/gcre_front.sv
// ----------------------------------------------------------------------------
// GCR encoder front end
// Accepts items, runs the checksum and group buffer, and turns every item
// that produces output into one job for the back end.
// ----------------------------------------------------------------------------
module gcre_front import gcre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,
   input  logic         req_push,
   input  logic [1:0]   req_operation,
   input  logic [7:0]   req_data_byte,
   input  logic         job_full,
   output logic         job_push,
   output gcre_job_type job
);

   logic             nibble_mode_ff;
   logic             active_ff,    active_in;
   logic [8:0]       sum_rot_ff,   sum_rot_in;
   logic [7:0]       sum_mid_ff,   sum_mid_in;
   logic [7:0]       sum_old_ff,   sum_old_in;
   logic [1:0]       gc_ff,        gc_in;
   logic [1:0][7:0]  gb_ff,        gb_in;

   logic             accept;
   gcre_op_type      op;
   logic             nib_err;
   logic [7:0]       val;
   logic [8:0]       rot_pre;
   logic [8:0]       sum_t;
   logic [7:0]       coded;
   logic [2:0]       pos;
   logic [3:0][5:0]  sum_idx;

   assign accept  = req_push && !job_full;
   assign op      = gcre_op_type'(req_operation);
   assign nib_err = nibble_mode_ff && (req_data_byte[7:6] != 2'b00);
   assign val     = nibble_mode_ff ? GCR_TABLE[req_data_byte[5:0]] : req_data_byte;

   // The rotating sum turns left by one at the start of each group of three.
   assign rot_pre = (gc_ff == 2'd0) ? {sum_rot_ff[7:0], sum_rot_ff[7]} : sum_rot_ff;
   assign sum_t   = {1'b0, sum_old_ff} + {1'b0, val} + {8'd0, rot_pre[8]};
   assign coded   = val ^ rot_pre[7:0];

   assign sum_idx[0] = {sum_mid_ff[7:6], sum_rot_ff[7:6], sum_old_ff[7:6]};
   assign sum_idx[1] = sum_mid_ff[5:0];
   assign sum_idx[2] = sum_rot_ff[5:0];
   assign sum_idx[3] = sum_old_ff[5:0];

   always_comb begin
      active_in  = active_ff;
      sum_rot_in = sum_rot_ff;
      sum_mid_in = sum_mid_ff;
      sum_old_in = sum_old_ff;
      gc_in      = gc_ff;
      gb_in      = gb_ff;
      job        = '0;
      pos        = 3'd0;
      case (op)
         OP_DATA: begin
            if (nib_err) begin
               job.raw   = 1'b1;
               job.err   = 1'b1;
               job.count = 3'd1;
            end else if (!active_ff) begin
               job.raw      = 1'b1;
               job.raw_byte = val;
               job.count    = 3'd1;
            end else begin
               sum_rot_in = sum_t;
               sum_mid_in = rot_pre[7:0];
               sum_old_in = sum_mid_ff;
               if (gc_ff == 2'd2) begin
                  job.idx[0] = {gb_ff[0][7:6], gb_ff[1][7:6], coded[7:6]};
                  job.idx[1] = gb_ff[0][5:0];
                  job.idx[2] = gb_ff[1][5:0];
                  job.idx[3] = coded[5:0];
                  job.count  = 3'd4;
                  gc_in      = 2'd0;
                  gb_in      = '0;
               end else begin
                  gb_in[gc_ff[0]] = coded;
                  gc_in           = gc_ff + 2'd1;
               end
            end
         end
         OP_START: begin
            active_in  = 1'b1;
            sum_rot_in = '0;
            sum_mid_in = '0;
            sum_old_in = '0;
            gc_in      = 2'd0;
            gb_in      = '0;
         end
         default: begin
            if (!active_ff) begin
               job.raw   = 1'b1;
               job.err   = 1'b1;
               job.count = 3'd1;
            end else begin
               // A partial group gives its high-bits byte and one byte per buffered byte.
               if (gc_ff != 2'd0) begin
                  job.idx[0] = {gb_ff[0][7:6], gb_ff[1][7:6], 2'b00};
                  job.idx[1] = gb_ff[0][5:0];
                  job.idx[2] = gb_ff[1][5:0];
                  pos        = {1'b0, gc_ff} + 3'd1;
               end
               if (op == OP_STOP_SUM) begin
                  for (int k = 0; k < 4; k++) begin
                     job.idx[pos + 3'(k)] = sum_idx[k];
                  end
                  job.count = pos + 3'd4;
               end else begin
                  job.count = pos;
               end
               active_in = 1'b0;
               gc_in     = 2'd0;
               gb_in     = '0;
            end
         end
      endcase
   end

   assign job_push = accept && (job.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_mode_ff <= 1'b0;
         active_ff      <= 1'b0;
         sum_rot_ff     <= '0;
         sum_mid_ff     <= '0;
         sum_old_ff     <= '0;
         gc_ff          <= '0;
         gb_ff          <= '0;
      end else begin
         if (csr_we) begin
            nibble_mode_ff <= csr_wdata;
         end
         if (accept) begin
            active_ff  <= active_in;
            sum_rot_ff <= sum_rot_in;
            sum_mid_ff <= sum_mid_in;
            sum_old_ff <= sum_old_in;
            gc_ff      <= gc_in;
            gb_ff      <= gb_in;
         end
      end
   end

endmodule

FILE: rtl/core/gcre_job_fifo.sv
// ----------------------------------------------------------------------------
// GCR encoder job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module gcre_job_fifo import gcre_pkg::*; #(
   parameter int DEPTH = JOB_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  gcre_job_type push_job,
   output logic         full,
   input  logic         pop,
   output gcre_job_type head_job,
   output logic         empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   gcre_job_type      mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff,  count_in;
   logic              push_ok;
   logic              pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/gcre_back.sv
// ----------------------------------------------------------------------------
// GCR encoder back end
// Walks through the head job one disk byte a cycle while the output slot is free
// and holds each result beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module gcre_back import gcre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  gcre_job_type head_job,
   input  logic         job_empty,
   output logic         job_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [7:0]   rsp_disk_byte,
   output logic         rsp_error,
   output logic         rsp_last
);

   logic [2:0]  cursor_ff, cursor_in;
   logic        valid_ff,  valid_in;
   logic [7:0]  byte_ff,   byte_in;
   logic        err_ff,    err_in;
   logic        last_ff,   last_in;
   logic        slot_free;
   logic        take;

   assign slot_free = !valid_ff || rsp_pop;
   assign take      = slot_free && !job_empty;

   always_comb begin
      last_in   = (cursor_ff == head_job.count - 3'd1);
      byte_in   = head_job.raw ? head_job.raw_byte : GCR_TABLE[head_job.idx[cursor_ff]];
      err_in    = head_job.err;
      job_pop   = take && last_in;
      cursor_in = cursor_ff;
      valid_in  = valid_ff;
      if (take) begin
         cursor_in = last_in ? 3'd0 : cursor_ff + 3'd1;
         valid_in  = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
         err_ff  <= err_in;
         last_ff <= last_in;
      end
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_disk_byte = byte_ff;
   assign rsp_error     = err_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: rtl/core/gcr_six_and_two_sector_encoder_core.sv
// With the back end idle, the first disk byte of an item goes through the job queue
// and the output register to the result ports; bytes of jobs already queued come first.
// Throughput: one item per cycle enters while the job queue has room; the back end
// delivers one disk byte per cycle while results are popped.
// A full group of three data bytes gives four disk bytes.
// Reset is synchronous and active high; it clears the checksum, mode and both queues.
// ----------------------------------------------------------------------------
// GCR 6-and-2 sector encoder
// Front end with running checksum, job queue and byte-serial back end.
// ----------------------------------------------------------------------------
module gcr_six_and_two_sector_encoder_core import gcre_pkg::*; #(
   parameter int JOB_DEPTH = JOB_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_disk_byte,
   output logic        rsp_error,
   output logic        rsp_last
);

   logic          job_push;
   logic          job_full;
   logic          job_pop;
   logic          job_empty;
   gcre_job_type  push_job;
   gcre_job_type  head_job;

   assign req_full = job_full;

   gcre_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .job_full      (job_full),
      .job_push      (job_push),
      .job           (push_job)
   );

   gcre_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   gcre_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .job_empty     (job_empty),
      .job_pop       (job_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_disk_byte (rsp_disk_byte),
      .rsp_error     (rsp_error),
      .rsp_last      (rsp_last)
   );

   // An error result always stands alone, so it must close its item.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> rsp_last)
      else $error("error result without last");

   a_no_job_overflow: assert property (@(posedge clock) disable iff (reset)
      !(job_push && job_full))
      else $error("job pushed into a full queue");

   a_job_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job popped from an empty queue");

   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result present straight after reset");

endmodule

FILE: dv/gcr_sector_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GCR sector encoder scoreboard
// Predicts the disk bytes of each accepted item from a private copy of the
// checksum, group buffer and mode, and checks popped beats against them.
// ----------------------------------------------------------------------------
package gcr_sector_scoreboard_pkg;
   import gcre_pkg::*;

   typedef struct packed {
      logic [7:0] disk_byte;
      logic       error;
      logic       last;
   } disk_beat_t;

   class gcr_sector_scoreboard;
      disk_beat_t expected_disk_beats[$];

      bit         nibble_mode;
      bit         check_active;
      logic [8:0] sum_rot;
      logic [7:0] sum_mid;
      logic [7:0] sum_old;
      logic [1:0] group_count;
      logic [7:0] group_bytes [2];

      int mismatches;
      int items_noted;
      int beats_checked;
      int rejects_predicted;
      int groups_predicted;
      int sums_predicted;

      function new();
         nibble_mode       = 1'b0;
         check_active      = 1'b0;
         sum_rot           = '0;
         sum_mid           = '0;
         sum_old           = '0;
         mismatches        = 0;
         items_noted       = 0;
         beats_checked     = 0;
         rejects_predicted = 0;
         groups_predicted  = 0;
         sums_predicted    = 0;
         clear_group();
      endfunction

      function void clear_group();
         group_count    = '0;
         group_bytes[0] = '0;
         group_bytes[1] = '0;
      endfunction

      function int pending();
         return expected_disk_beats.size();
      endfunction

      function void add_beat(logic [7:0] disk_byte, logic error);
         disk_beat_t beat;
         beat.disk_byte = disk_byte;
         beat.error     = error;
         beat.last      = 1'b0;
         expected_disk_beats.push_back(beat);
      endfunction

      // High bit pairs first, then the low six bits of each byte present.
      function void add_group(logic [7:0] a, logic [7:0] b, logic [7:0] c, int cnt);
         logic [5:0] hi;
         hi = {a[7:6], b[7:6], c[7:6]};
         add_beat(GCR_TABLE[hi], 1'b0);
         add_beat(GCR_TABLE[a[5:0]], 1'b0);
         if (cnt >= 2) add_beat(GCR_TABLE[b[5:0]], 1'b0);
         if (cnt >= 3) add_beat(GCR_TABLE[c[5:0]], 1'b0);
         groups_predicted++;
      endfunction

      function void note_accepted_item(gcre_op_type op, logic [7:0] data_byte);
         int         first;
         logic [7:0] value;
         logic [9:0] total;
         first = expected_disk_beats.size();
         value = data_byte;
         items_noted++;
         case (op)
            OP_DATA: begin
               if (nibble_mode && value > 8'd63) begin
                  add_beat(8'h00, 1'b1);
                  rejects_predicted++;
               end else begin
                  if (nibble_mode) value = GCR_TABLE[value[5:0]];
                  if (!check_active) begin
                     add_beat(value, 1'b0);
                  end else begin
                     if (group_count == 2'd0) sum_rot = {sum_rot[7:0], sum_rot[7]};
                     total   = {2'b00, sum_old} + {2'b00, value} + {9'd0, sum_rot[8]};
                     sum_old = sum_mid;
                     sum_mid = sum_rot[7:0];
                     sum_rot = total[8:0];
                     value   = value ^ sum_mid;
                     if (group_count >= 2'd2) begin
                        add_group(group_bytes[0], group_bytes[1], value, 3);
                        clear_group();
                     end else begin
                        group_bytes[group_count[0]] = value;
                        group_count++;
                     end
                  end
               end
            end
            OP_START: begin
               check_active = 1'b1;
               sum_rot      = '0;
               sum_mid      = '0;
               sum_old      = '0;
               clear_group();
            end
            default: begin
               if (!check_active) begin
                  add_beat(8'h00, 1'b1);
                  rejects_predicted++;
               end else begin
                  if (group_count > 2'd0)
                     add_group(group_bytes[0], group_bytes[1], 8'h00, int'(group_count));
                  check_active = 1'b0;
                  clear_group();
                  if (op == OP_STOP_SUM) begin
                     add_group(sum_mid, sum_rot[7:0], sum_old, 3);
                     sums_predicted++;
                  end
               end
            end
         endcase
         if (expected_disk_beats.size() > first)
            expected_disk_beats[expected_disk_beats.size() - 1].last = 1'b1;
      endfunction

      task report_mismatch(string what, int want, int got);
         mismatches++;
         $display("[%0t] mismatch on beat %0d: %s expected 0x%0h, got 0x%0h",
                  $time, beats_checked, what, want, got);
      endtask

      task check_disk_beat(logic [7:0] disk_byte, logic error, logic last);
         disk_beat_t want;
         if (expected_disk_beats.size() == 0) begin
            report_mismatch("unexpected beat, disk_byte", 0, disk_byte);
         end else begin
            want = expected_disk_beats.pop_front();
            if (disk_byte !== want.disk_byte)
               report_mismatch("disk_byte", want.disk_byte, disk_byte);
            if (error !== want.error) report_mismatch("error", want.error, error);
            if (last !== want.last) report_mismatch("last", want.last, last);
         end
         beats_checked++;
      endtask
   endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GCR 6-and-2 sector encoder testbench
// Drives directed and random item streams through the queue-style ports in
// both nibble modes, with random gaps on both sides, and checks every disk
// byte against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import gcre_pkg::*;
   import gcr_sector_scoreboard_pkg::*;

   localparam int DRAIN_SLACK    = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 35;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       csr_we        = 1'b0;
   logic       csr_wdata     = 1'b0;
   logic       req_push      = 1'b0;
   logic [1:0] req_operation = OP_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_pop       = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_disk_byte;
   logic       rsp_error;
   logic       rsp_last;

   int send_gap_max  = 17;
   int pop_stall_max = 17;
   int items_sent    = 0;
   int idle_cycles   = 0;
   bit modes_seen [2];

   gcr_sector_scoreboard sector_sb = new();

   gcr_six_and_two_sector_encoder_core dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_disk_byte (rsp_disk_byte),
      .rsp_error     (rsp_error),
      .rsp_last      (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Both channels are observed on the same edge the block sees them.
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset && req_push && req_full === 1'b0) begin
         sector_sb.note_accepted_item(gcre_op_type'(req_operation), req_data_byte);
         moved = 1'b1;
      end
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         sector_sb.check_disk_beat(rsp_disk_byte, rsp_error, rsp_last);
         moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   initial begin : pop_side
      int stall;
      forever begin
         stall = $urandom_range(0, pop_stall_max);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (reset || rsp_empty !== 1'b0);
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[%0t] no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // Push stays high after a beat when the next item follows with no gap.
   task automatic push_item(input gcre_op_type op, input logic [7:0] data_byte);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_operation <= op;
      req_data_byte <= data_byte;
      do @(posedge clock); while (req_full !== 1'b0);
      items_sent++;
   endtask

   task automatic hold_sender_off();
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      while (sector_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_nibble_mode(input bit mode);
      hold_sender_off();
      wait_until_drained();
      csr_wdata <= mode;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      sector_sb.nibble_mode = mode;
      modes_seen[mode] = 1'b1;
   endtask

   function automatic logic [7:0] pick_data_byte(input bit nibble);
      if (nibble && $urandom_range(0, 7) != 0) begin
         case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd63;
            default: return 8'($urandom_range(0, 63));
         endcase
      end
      return 8'($urandom);
   endfunction

   // Mostly complete sectors with random content; the rest is loose noise.
   task automatic send_sector_run(input bit nibble);
      int n_bytes;
      int pause_at;
      if ($urandom_range(0, 9) < 8) begin
         push_item(OP_START, 8'($urandom));
         n_bytes  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                : $urandom_range(0, 9);
         pause_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n_bytes) : -1;
         for (int i = 0; i < n_bytes; i++) begin
            if (i == pause_at) begin
               hold_sender_off();
               wait_until_drained();
            end
            push_item(OP_DATA, pick_data_byte(nibble));
         end
         push_item($urandom_range(0, 1) ? OP_STOP_SUM : OP_STOP, 8'($urandom));
      end else begin
         push_item(gcre_op_type'($urandom_range(0, 3)), pick_data_byte(nibble));
      end
   endtask

   initial begin : stimulus
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Raw mode: pass-through, rejected stops, full and partial groups.
      write_nibble_mode(1'b0);
      push_item(OP_DATA, 8'h00);
      push_item(OP_DATA, 8'hff);
      push_item(OP_STOP, 8'h00);
      push_item(OP_STOP_SUM, 8'hff);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'h00);
      push_item(OP_DATA, 8'hff);
      push_item(OP_DATA, 8'h5a);
      push_item(OP_DATA, 8'hc3);
      // The sender waits here for the encoder to run dry mid-sector.
      hold_sender_off();
      wait_until_drained();
      push_item(OP_STOP, 8'h00);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'hff);
      push_item(OP_DATA, 8'h80);
      push_item(OP_STOP_SUM, 8'h00);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'h7e);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'h01);
      push_item(OP_STOP_SUM, 8'h00);

      // Nibble mode: table mapping and out-of-range values, also mid-sector.
      write_nibble_mode(1'b1);
      push_item(OP_DATA, 8'd0);
      push_item(OP_DATA, 8'd63);
      push_item(OP_DATA, 8'd64);
      push_item(OP_DATA, 8'hff);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'd63);
      push_item(OP_DATA, 8'h80);
      push_item(OP_STOP_SUM, 8'h00);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_nibble_mode(phase[0]);
         send_gap_max  = (phase % 3 == 1) ? 0 : 17;
         pop_stall_max = (phase % 4 == 2) ? 0 : 17;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_sector_run(phase[0]);
      end

      hold_sender_off();
      wait_until_drained();

      $display("Sent %0d items in both nibble modes (%0d/%0d); checked %0d disk bytes.",
               items_sent, modes_seen[0], modes_seen[1], sector_sb.beats_checked);
      $display("Predicted %0d GCR groups, %0d checksum groups, %0d rejected items.",
               sector_sb.groups_predicted, sector_sb.sums_predicted,
               sector_sb.rejects_predicted);
      if (sector_sb.mismatches == 0 && sector_sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
